// ===== design/udiv_pkg.sv =====
// shared types for the pipelined restoring divider
package udiv_pkg;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic zero;
    } t_flow;

endpackage

// ===== design/udiv_stage.sv =====
// one restoring division step: shift in a dividend bit, trial subtract, keep or restore
module udiv_stage #(
    parameter int W = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  udiv_pkg::t_flow i_flow,
    input  logic [W-1:0]   i_rem,
    input  logic [W-1:0]   i_nq,
    input  logic [W-1:0]   i_den,
    output udiv_pkg::t_flow o_flow,
    output logic [W-1:0]   o_rem,
    output logic [W-1:0]   o_nq,
    output logic [W-1:0]   o_den
);
    import udiv_pkg::*;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_nq;

    t_flow        r_flow;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_nq;
    logic [W-1:0] r_den;

    // partial remainder is one bit wider than the operands during the trial
    assign trial = {i_rem, i_nq[W-1]};
    assign diff  = trial - {1'b0, i_den};
    assign ge    = ~diff[W];
    assign n_rem = ge ? diff[W-1:0] : trial[W-1:0];
    // dividend bits leave at the top while quotient bits enter at the bottom
    assign n_nq  = {i_nq[W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow <= '0;
        end else if (i_en) begin
            r_flow <= i_flow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
        end
    end

    assign o_flow = r_flow;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
    assign o_den  = r_den;

endmodule

// ===== design/udiv_out.sv =====
// output register with skid entry, holds the pipeline once the skid entry fills while the receiver stalls
module udiv_out #(
    parameter int W = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  udiv_pkg::t_flow i_flow,
    input  logic [W-1:0]    i_quo,
    input  logic [W-1:0]    i_rem,
    output logic            o_en,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [W-1:0]    o_quotient,
    output logic [W-1:0]    o_leftover,
    output logic            o_zero_divisor
);
    import udiv_pkg::*;

    logic         r_out_valid;
    logic [W-1:0] r_out_quo;
    logic [W-1:0] r_out_rem;
    logic         r_out_zero;
    logic         r_skid_valid;
    logic [W-1:0] r_skid_quo;
    logic [W-1:0] r_skid_rem;
    logic         r_skid_zero;

    logic         in_v;
    logic         take;
    logic [W-1:0] n_quo;
    logic [W-1:0] n_rem;

    assign o_en  = ~r_skid_valid;
    assign in_v  = i_flow.valid & o_en;
    assign take  = r_out_valid & ~i_stall;
    // zero divisor forces both results to zero
    assign n_quo = i_flow.zero ? '0 : i_quo;
    assign n_rem = i_flow.zero ? '0 : i_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_v;
            end
        end else if (in_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_quo  <= r_skid_quo;
                r_out_rem  <= r_skid_rem;
                r_out_zero <= r_skid_zero;
            end else begin
                r_out_quo  <= n_quo;
                r_out_rem  <= n_rem;
                r_out_zero <= i_flow.zero;
            end
        end else if (in_v) begin
            r_skid_quo  <= n_quo;
            r_skid_rem  <= n_rem;
            r_skid_zero <= i_flow.zero;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_quotient     = r_out_quo;
    assign o_leftover     = r_out_rem;
    assign o_zero_divisor = r_out_zero;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not move to output after transfer");

    a_zero_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_out_quo == '0 && r_out_rem == '0))
        else $error("zero divisor result not cleared");

endmodule

// ===== design/unsigned_divider_64.sv =====
// top level of the pipelined unsigned restoring divider
//
// input channel: i_valid, i_dividend, i_divisor; a transfer happens at a clock
// edge with i_valid high and o_stall low. output channel: o_valid, o_quotient,
// o_leftover, o_zero_divisor; a transfer happens with o_valid high and i_stall low.
// each item gives exactly one result, in order.
// throughput: one division per cycle while o_stall is low, back to back, with no gaps.
// structure: one pipeline stage per quotient bit (one DATA_WIDTH+1 bit subtract
// and compare each) plus the output register.
// a zero divisor returns zero quotient and leftover with o_zero_divisor set.
// when the receiver stalls, the pipeline keeps advancing until a skid entry
// behind the output register fills; o_stall then rises (it comes straight from
// that register) and the whole pipeline holds until the output drains.
// reset is synchronous, active low, and clears all valid bits; no result is
// pending after reset and o_stall is low.
module unsigned_divider_64 #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_leftover,
    output logic                  o_zero_divisor
);
    import udiv_pkg::*;

    localparam int W = DATA_WIDTH;

    logic            en;
    t_flow           s_flow [0:W];
    logic [W-1:0]    s_rem  [0:W];
    logic [W-1:0]    s_nq   [0:W];
    logic [W-1:0]    s_den  [0:W];

    assign s_flow[0].valid = i_valid;
    assign s_flow[0].zero  = (i_divisor == '0);
    assign s_rem[0]        = '0;
    assign s_nq[0]         = i_dividend;
    assign s_den[0]        = i_divisor;

    for (genvar k = 0; k < W; k++) begin : g_step
        udiv_stage #(.W(W)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_flow  (s_flow[k]),
            .i_rem   (s_rem[k]),
            .i_nq    (s_nq[k]),
            .i_den   (s_den[k]),
            .o_flow  (s_flow[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_nq    (s_nq[k+1]),
            .o_den   (s_den[k+1])
        );
    end

    udiv_out #(.W(W)) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_flow         (s_flow[W]),
        .i_quo          (s_nq[W]),
        .i_rem          (s_rem[W]),
        .o_en           (en),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_quotient     (o_quotient),
        .o_leftover     (o_leftover),
        .o_zero_divisor (o_zero_divisor)
    );

    assign o_stall = ~en;

endmodule

// ===== verif/tb.sv =====
// testbench for the pipelined 64-bit unsigned restoring divider
`timescale 1ns / 100ps

module tb;

    localparam int W = 64;
    localparam int ITEMS = 1650;
    localparam int TAIL_ITEMS = 150;
    localparam logic [W-1:0] ALL_ONES = '1;
    localparam logic [W-1:0] TOP_BIT = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0] quotient;
        logic [W-1:0] leftover;
        logic         zero_divisor;
    } t_division;

    class t_division_book;
        t_division   queued_answers[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        // long division with a partial remainder one bit wider than the operands
        function t_division restoring_divide(logic [W-1:0] num, logic [W-1:0] den);
            t_division  answer;
            logic [W:0] part;
            int         k;
            answer = '0;
            part = '0;
            if (den == '0) begin
                answer.zero_divisor = 1'b1;
                return answer;
            end
            for (k = W - 1; k >= 0; k--) begin
                part = {part[W-1:0], num[k]};
                if (part >= {1'b0, den}) begin
                    part = part - {1'b0, den};
                    answer.quotient[k] = 1'b1;
                end
            end
            answer.leftover = part[W-1:0];
            return answer;
        endfunction

        function void note_operands(logic [W-1:0] num, logic [W-1:0] den);
            queued_answers.push_back(restoring_divide(num, den));
        endfunction

        function void check_division(logic [W-1:0] quo, logic [W-1:0] rem, logic zdiv);
            t_division want;
            if (queued_answers.size() == 0) begin
                $display("%0t: unexpected result quotient %h leftover %h zero_divisor %b",
                         $time, quo, rem, zdiv);
                failures++;
                return;
            end
            want = queued_answers.pop_front();
            if (quo !== want.quotient) begin
                $display("%0t: quotient expected %h actual %h", $time, want.quotient, quo);
                failures++;
            end
            if (rem !== want.leftover) begin
                $display("%0t: leftover expected %h actual %h", $time, want.leftover, rem);
                failures++;
            end
            if (zdiv !== want.zero_divisor) begin
                $display("%0t: zero_divisor expected %b actual %b",
                         $time, want.zero_divisor, zdiv);
                failures++;
            end
        endfunction

        function int waiting();
            return queued_answers.size();
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    logic [W-1:0] i_dividend = '0;
    logic [W-1:0] i_divisor = '0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    logic [W-1:0] o_quotient;
    logic [W-1:0] o_leftover;
    logic         o_zero_divisor;

    t_division_book book = new();
    int           sent = 0;
    bit           quiet_tail = 1'b0;
    bit           gaps_on = 1'b1;

    unsigned_divider_64 #(.DATA_WIDTH(W)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_dividend     (i_dividend),
        .i_divisor      (i_divisor),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_quotient     (o_quotient),
        .o_leftover     (o_leftover),
        .o_zero_divisor (o_zero_divisor)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // called right after an edge; returns after the transfer edge and any idle gap
    task automatic send_division(logic [W-1:0] num, logic [W-1:0] den);
        i_valid <= 1'b1;
        i_dividend <= num;
        i_divisor <= den;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        book.note_operands(num, den);
        sent++;
        if (sent % 64 == 0)
            gaps_on = ($urandom_range(0, 2) != 0);
        if (sent >= ITEMS - TAIL_ITEMS)
            quiet_tail = 1'b1;
        if (!quiet_tail && gaps_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_division();
        logic [W-1:0] num;
        logic [W-1:0] den;
        num = rand_word();
        den = rand_word();
        case ($urandom_range(0, 9))
            0: den = '0;
            1: den = den >> $urandom_range(0, W - 1);
            2: begin
                num = num >> $urandom_range(0, W - 1);
                den = den >> $urandom_range(0, W - 1);
            end
            3: den = ALL_ONES - $urandom_range(0, 255);
            4: begin
                // dividend below divisor
                den = den | TOP_BIT;
                num = num >> $urandom_range(1, W - 1);
            end
            5: begin
                den = den >> (W / 2);
                num = den * {32'd0, $urandom};
            end
            6: num = $urandom_range(0, 1) ? ALL_ONES : TOP_BIT;
            default: ;
        endcase
        send_division(num, den);
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_division('0, '0);
        send_division(ALL_ONES, '0);
        send_division(rand_word(), '0);
        send_division('0, 64'd1);
        send_division(ALL_ONES, 64'd1);
        send_division(64'd1, 64'd1);
        send_division('0, ALL_ONES);
        send_division(ALL_ONES, ALL_ONES);
        send_division(ALL_ONES - 1, ALL_ONES);
        send_division(ALL_ONES, ALL_ONES - 1);
        send_division(64'd1, ALL_ONES);
        send_division(ALL_ONES, TOP_BIT);
        send_division(TOP_BIT, TOP_BIT + 1);
        send_division(TOP_BIT, 64'd1);
        send_division(ALL_ONES, TOP_BIT - 1);
        send_division(ALL_ONES, 64'd3);
        send_division(64'd123, 64'd7);
        send_division(64'd7, 64'd123);
        send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_division(64'h5555_5555_5555_5555, 64'h0000_0000_0000_0002);

        while (sent < ITEMS) send_random_division();
        i_valid <= 1'b0;

        while (book.waiting() != 0) @(posedge i_clk);
        repeat (W + 8) @(posedge i_clk);

        if (book.waiting() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, book.waiting());
            book.failures++;
        end
        if (book.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side: check transfers and stall in random bursts
    initial begin : result_side
        int run_left;
        bit stall_next;
        run_left = 0;
        stall_next = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                book.check_division(o_quotient, o_leftover, o_zero_divisor);
            if (run_left == 0) begin
                if (quiet_tail || $urandom_range(0, 2) != 0) begin
                    stall_next = 1'b0;
                    run_left = $urandom_range(1, 40);
                end else begin
                    stall_next = 1'b1;
                    run_left = $urandom_range(1, 12);
                end
            end
            run_left--;
            i_stall <= stall_next && !quiet_tail;
        end
    end

endmodule
